>>> hdl/assert_macros.svh
// Assertion macros for the colorizer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LRC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lrc assertion failed");
`define LRC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("lrc assertion failed");
`else
`define LRC_ASSERT(lbl, prop)
`define LRC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> hdl/lrc_pkg.sv
// Shared constants and types of the level to RGB colorizer
`default_nettype none
package lrc_pkg;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_SEG     = 7;
    localparam int RECIP_BITS  = 22;
    localparam int RECIP_SHIFT = 14;

    typedef logic [FRAC_BITS:0] q16_t;
    typedef logic [2:0]         seg_t;
    typedef logic [2:0]         rgb_bits_t;
    typedef logic [1:0]         reg_idx_t;
    typedef logic [RECIP_BITS-1:0] recip_t;

    localparam reg_idx_t REG_MAX_LEVEL    = 2'd0;
    localparam reg_idx_t REG_IMAGE_WIDTH  = 2'd1;
    localparam reg_idx_t REG_IMAGE_HEIGHT = 2'd2;
    localparam reg_idx_t REG_ADD_BORDER   = 2'd3;

    localparam q16_t ONE_Q16 = 17'h10000;

    localparam q16_t SEG_CUT [0:NUM_SEG] = '{
        17'd0, 17'd10945, 17'd21823, 17'd32768,
        17'd43713, 17'd54591, 17'd65208, 17'd65536
    };

    // floor(2^30 / segment span); quotient is low by at most one
    localparam recip_t SEG_RECIP [0:NUM_SEG-1] = '{
        22'd98103, 22'd98707, 22'd98103, 22'd98103,
        22'd98707, 22'd101134, 22'd3273603
    };

    // {red, green, blue}; last entry repeats white for the top segment
    localparam rgb_bits_t PALETTE [0:NUM_SEG] = '{
        3'b101, 3'b001, 3'b011, 3'b010,
        3'b110, 3'b100, 3'b111, 3'b111
    };

    typedef struct packed {
        logic blk;
        seg_t seg;
    } shade_side_t;
endpackage
`default_nettype wire

>>> hdl/level_to_rgb_colorizer.sv
// Level to RGB colorizer top level: register port, input stage, pipeline
// Throughput: one request per cycle; busy is never raised.
// The divider and square root are 17-stage bit-per-cycle pipelines.
// Reset: asynchronous active low, clears valid bits and loads register defaults.
// The receiver cannot stall; each result shows for exactly one cycle.
`default_nettype none
`include "assert_macros.svh"
module level_to_rgb_colorizer
    import lrc_pkg::*;
#(
    parameter int LEVEL_BITS = 16,
    parameter int DIM_BITS   = 12
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [LEVEL_BITS-1:0] level,
    input  wire logic [DIM_BITS-1:0]   column,
    input  wire logic [DIM_BITS-1:0]   row,
    output logic                       done,
    output logic [7:0]                 red_byte,
    output logic [7:0]                 green_byte,
    output logic [7:0]                 blue_byte
);
    localparam int LB = LEVEL_BITS;
    localparam int DB = DIM_BITS + 1;

    logic [LB-1:0] max_level_reg;
    logic [DB-1:0] image_width_reg;
    logic [DB-1:0] image_height_reg;
    logic          add_border_reg;
    reg_idx_t      cfg_idx;
    logic          cfg_wr;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg    <= LB'(256);
            image_width_reg  <= DB'(640);
            image_height_reg <= DB'(480);
            add_border_reg   <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MAX_LEVEL:    max_level_reg    <= pwdata[LB-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[DB-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[DB-1:0];
                REG_ADD_BORDER:   add_border_reg   <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_MAX_LEVEL:    prdata = 32'(max_level_reg);
            REG_IMAGE_WIDTH:  prdata = 32'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(image_height_reg);
            REG_ADD_BORDER:   prdata = 32'(add_border_reg);
            default:          prdata = '0;
        endcase
    end

    // input stage: clamp and edge test
    logic [LB-1:0] mx;
    logic [DB-1:0] last_col;
    logic [DB-1:0] last_row;
    logic          edge_px;
    logic          in_valid_reg;
    logic [LB-1:0] lvl_reg;
    logic [LB-1:0] mx_reg;
    logic          blk_reg;

    assign mx       = (max_level_reg == '0) ? LB'(1) : max_level_reg;
    assign last_col = image_width_reg - DB'(1);
    assign last_row = image_height_reg - DB'(1);
    assign edge_px  = (column == '0) || (row == '0)
                   || ({1'b0, column} == last_col) || ({1'b0, row} == last_row);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg <= (level > mx) ? mx : level;
        mx_reg  <= mx;
        blk_reg <= add_border_reg && edge_px;
    end

    // normalise
    logic n_valid;
    q16_t n_q;
    logic n_blk;

    lrc_div #(.NW(LB), .SW(1)) u_norm_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .num      (lvl_reg),
        .den      (mx_reg),
        .side_in  (blk_reg),
        .out_valid(n_valid),
        .quo      (n_q),
        .side_out (n_blk)
    );

    // segment select
    seg_t        seg_sel;
    logic        seg_valid_reg;
    q16_t        n_reg;
    q16_t        off_reg;
    q16_t        span_reg;
    shade_side_t seg_side_reg;

    always_comb
    begin
        seg_sel = 3'(NUM_SEG - 1);
        for (int k = NUM_SEG - 1; k >= 0; k--)
        begin
            if (n_q <= SEG_CUT[k+1])
            begin
                seg_sel = 3'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            seg_valid_reg <= n_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg            <= n_q;
        off_reg          <= n_q - SEG_CUT[seg_sel];
        span_reg         <= SEG_CUT[seg_sel + 3'd1] - SEG_CUT[seg_sel];
        seg_side_reg.blk <= n_blk;
        seg_side_reg.seg <= seg_sel;
    end

    // weight: reciprocal multiply, one correction step, then aligned to the root
    localparam int W_ALIGN = FRAC_BITS - 2;

    logic [2:0]                      wt_valid_reg;
    logic [FRAC_BITS+RECIP_BITS:0]   wt_prod_reg;
    q16_t                            wt_off1_reg;
    q16_t                            wt_span1_reg;
    shade_side_t                     wt_side1_reg;
    q16_t                            wt_q0_reg;
    logic [2*FRAC_BITS+1:0]          wt_qs_reg;
    q16_t                            wt_off2_reg;
    q16_t                            wt_span2_reg;
    shade_side_t                     wt_side2_reg;
    q16_t                            wt_w_reg;
    shade_side_t                     wt_side3_reg;
    logic [2*FRAC_BITS:0]            wt_rem_next;
    logic [W_ALIGN-1:0]              al_valid_reg;
    q16_t                            al_w_reg    [W_ALIGN];
    shade_side_t                     al_side_reg [W_ALIGN];

    assign wt_rem_next = {wt_off2_reg, {FRAC_BITS{1'b0}}} - wt_qs_reg[2*FRAC_BITS:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wt_valid_reg <= '0;
            al_valid_reg <= '0;
        end
        else
        begin
            wt_valid_reg <= {wt_valid_reg[1:0], seg_valid_reg};
            al_valid_reg <= {al_valid_reg[W_ALIGN-2:0], wt_valid_reg[2]};
        end
    end

    always_ff @(posedge clk)
    begin
        wt_prod_reg  <= off_reg * SEG_RECIP[seg_side_reg.seg];
        wt_off1_reg  <= off_reg;
        wt_span1_reg <= span_reg;
        wt_side1_reg <= seg_side_reg;

        wt_q0_reg    <= wt_prod_reg[RECIP_SHIFT +: FRAC_BITS + 1];
        wt_qs_reg    <= wt_prod_reg[RECIP_SHIFT +: FRAC_BITS + 1] * wt_span1_reg;
        wt_off2_reg  <= wt_off1_reg;
        wt_span2_reg <= wt_span1_reg;
        wt_side2_reg <= wt_side1_reg;

        wt_w_reg     <= (wt_rem_next >= {{FRAC_BITS{1'b0}}, wt_span2_reg})
                      ? wt_q0_reg + q16_t'(1) : wt_q0_reg;
        wt_side3_reg <= wt_side2_reg;

        al_w_reg[0]    <= wt_w_reg;
        al_side_reg[0] <= wt_side3_reg;
        for (int k = 1; k < W_ALIGN; k++)
        begin
            al_w_reg[k]    <= al_w_reg[k-1];
            al_side_reg[k] <= al_side_reg[k-1];
        end
    end

    // brightness in parallel
    logic        w_valid;
    q16_t        w_q;
    shade_side_t w_side;
    logic        adj_valid;
    q16_t        adj_q;

    assign w_valid = al_valid_reg[W_ALIGN-1];
    assign w_q     = al_w_reg[W_ALIGN-1];
    assign w_side  = al_side_reg[W_ALIGN-1];

    lrc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (seg_valid_reg),
        .n        (n_reg),
        .out_valid(adj_valid),
        .root     (adj_q)
    );

    lrc_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (w_valid),
        .side      (w_side),
        .w         (w_q),
        .adj       (adj_q),
        .done      (done),
        .red_byte  (red_byte),
        .green_byte(green_byte),
        .blue_byte (blue_byte)
    );

    `LRC_ASSERT(a_units_aligned, w_valid == adj_valid)
    `LRC_ASSERT(a_norm_to_seg, n_valid |=> seg_valid_reg)
    `LRC_ASSERT(a_seg_range, seg_valid_reg |-> (seg_side_reg.seg <= 3'(NUM_SEG - 1)))
    `LRC_ASSERT_ALWAYS(a_never_busy, !busy)
endmodule
`default_nettype wire

>>> hdl/lrc_div.sv
// Pipelined restoring divider, Q1.16 quotient of num/den with num <= den
`default_nettype none
module lrc_div
    import lrc_pkg::*;
#(
    parameter int NW = 16,
    parameter int SW = 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] num,
    input  wire logic [NW-1:0] den,
    input  wire logic [SW-1:0] side_in,
    output logic               out_valid,
    output q16_t               quo,
    output logic [SW-1:0]      side_out
);
    localparam int NST = FRAC_BITS + 1;

    logic          valid_reg [NST];
    logic [NW-1:0] rem_reg   [NST];
    logic [NW-1:0] den_reg   [NST];
    q16_t          q_reg     [NST];
    logic [SW-1:0] side_reg  [NST];

    logic          ge0_next;
    logic [NW-1:0] rem0_next;

    assign ge0_next  = num >= den;
    assign rem0_next = ge0_next ? NW'(num - den) : num;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= rem0_next;
        den_reg[0]  <= den;
        q_reg[0]    <= {{FRAC_BITS{1'b0}}, ge0_next};
        side_reg[0] <= side_in;
    end

    for (genvar i = 1; i < NST; i++)
    begin : g_stage
        logic [NW:0]   r2_next;
        logic          ge_next;
        logic [NW-1:0] rem_next;

        assign r2_next  = {rem_reg[i-1], 1'b0};
        assign ge_next  = r2_next >= {1'b0, den_reg[i-1]};
        assign rem_next = ge_next ? NW'(r2_next - {1'b0, den_reg[i-1]}) : r2_next[NW-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= rem_next;
            den_reg[i]  <= den_reg[i-1];
            q_reg[i]    <= {q_reg[i-1][FRAC_BITS-1:0], ge_next};
            side_reg[i] <= side_reg[i-1];
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign quo       = q_reg[NST-1];
    assign side_out  = side_reg[NST-1];
endmodule
`default_nettype wire

>>> hdl/lrc_sqrt.sv
// Pipelined digit-by-digit square root of n * 2^16
`default_nettype none
module lrc_sqrt
    import lrc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  q16_t      n,
    output logic      out_valid,
    output q16_t      root
);
    localparam int NST = FRAC_BITS + 1;
    localparam int VW  = 2 * NST;
    localparam int RW  = NST + 3;

    logic          valid_reg [NST];
    logic [VW-1:0] v_reg     [NST];
    logic [RW-1:0] rem_reg   [NST];
    q16_t          root_reg  [NST];

    logic [VW-1:0] v_in;
    assign v_in = {1'b0, n, {FRAC_BITS{1'b0}}};

    for (genvar j = 0; j < NST; j++)
    begin : g_stage
        logic [VW-1:0] v_src;
        logic [RW-1:0] rem_src;
        q16_t          root_src;
        logic          valid_src;
        logic [RW-1:0] rem_next;
        logic [RW-1:0] trial_next;
        logic          ge_next;

        if (j == 0)
        begin : g_first
            assign v_src     = v_in;
            assign rem_src   = '0;
            assign root_src  = '0;
            assign valid_src = in_valid;
        end
        else
        begin : g_rest
            assign v_src     = v_reg[j-1];
            assign rem_src   = rem_reg[j-1];
            assign root_src  = root_reg[j-1];
            assign valid_src = valid_reg[j-1];
        end

        assign rem_next   = {rem_src[RW-3:0], v_src[VW-1-2*j -: 2]};
        assign trial_next = RW'({root_src, 2'b01});
        assign ge_next    = rem_next >= trial_next;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else
            begin
                valid_reg[j] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            v_reg[j]    <= v_src;
            rem_reg[j]  <= ge_next ? RW'(rem_next - trial_next) : rem_next;
            root_reg[j] <= {root_src[FRAC_BITS-1:0], ge_next};
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign root      = root_reg[NST-1];
endmodule
`default_nettype wire

>>> hdl/lrc_shade.sv
// Colour mix, brightness scaling and byte output stages
`default_nettype none
module lrc_shade
    import lrc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  shade_side_t side,
    input  q16_t       w,
    input  q16_t       adj,
    output logic       done,
    output logic [7:0] red_byte,
    output logic [7:0] green_byte,
    output logic [7:0] blue_byte
);
    logic             valid_reg;
    logic             blk_reg;
    logic [33:0]      prod_reg [3];
    logic [7:0]       byte_next [3];
    logic             done_reg;
    logic [7:0]       byte_reg [3];
    rgb_bits_t        own;
    rgb_bits_t        nxt;
    q16_t             mix [3];

    assign own = PALETTE[side.seg];
    assign nxt = PALETTE[side.seg + 3'd1];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            case ({own[2-k], nxt[2-k]})
                2'b11:   mix[k] = ONE_Q16;
                2'b10:   mix[k] = w;
                2'b01:   mix[k] = ONE_Q16 - w;
                default: mix[k] = '0;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            byte_next[k] = blk_reg ? 8'd0
                         : 8'(({prod_reg[k], 8'd0} - {8'd0, prod_reg[k]}) >> 32);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= side.blk;
        for (int k = 0; k < 3; k++)
        begin
            prod_reg[k] <= adj * mix[k];
            byte_reg[k] <= byte_next[k];
        end
    end

    assign done       = done_reg;
    assign red_byte   = byte_reg[0];
    assign green_byte = byte_reg[1];
    assign blue_byte  = byte_reg[2];
endmodule
`default_nettype wire
